[rtl/utf8d_pkg.sv]
// shared types and constants for the utf-8 byte stream decoder
`timescale 1ns / 1ps

package utf8d_pkg;

  localparam int CP_W = 21;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BAD   = 2'd1;
  localparam logic [1:0] ST_TRUNC = 2'd2;
  localparam logic [1:0] ST_LEAD  = 2'd3;

  localparam logic [CP_W-1:0] CP_SPACE = 21'h00020;
  localparam logic [CP_W-1:0] CP_QUEST = 21'h0003F;
  localparam logic [CP_W-1:0] CP_STAR  = 21'h0002A;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_of_string;
  } in_beat_t;

  typedef struct packed {
    logic            valid_res;
    logic [CP_W-1:0] code_point;
    logic [1:0]      status;
    logic            string_end;
  } out_beat_t;

endpackage

[rtl/utf8_byte_stream_decoder.sv]
// utf-8 byte stream decoder: input register, decode logic, result register
// throughput: one byte per cycle while the result is not stalled; the sequence state (pending count, partial
//   code point, bad flag) is updated in the single decode stage as each byte advances
// reset: synchronous, active low; clears the valid bits of both stages and the sequence state
`timescale 1ns / 1ps

module utf8_byte_stream_decoder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  utf8d_pkg::in_beat_t in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output utf8d_pkg::out_beat_t out_data
);
  import utf8d_pkg::*;

  logic            s1_valid_r;
  in_beat_t        s1_data_r;
  logic            s1_adv;
  logic            out_valid_r;
  out_beat_t       out_data_r;
  out_beat_t       res_nxt;

  logic [1:0]      pend_r, pend_nxt;
  logic [CP_W-1:0] part_r, part_nxt;
  logic            bad_r, bad_nxt;
  logic [7:0]      b;
  logic            last;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign b    = s1_data_r.byte_value;
  assign last = s1_data_r.last_of_string;

  always_comb begin
    pend_nxt = pend_r;
    part_nxt = part_r;
    bad_nxt  = bad_r;
    res_nxt.valid_res  = 1'b0;
    res_nxt.code_point = '0;
    res_nxt.status     = ST_OK;
    res_nxt.string_end = last;
    if (pend_r == 2'd0) begin
      if (b[7:5] == 3'b000) begin
        res_nxt.valid_res  = 1'b1;
        res_nxt.code_point = CP_SPACE;
      end else if (!b[7]) begin
        res_nxt.valid_res  = 1'b1;
        res_nxt.code_point = {13'd0, b};
      end else if (b[7:6] == 2'b10) begin
        // stray continuation, dropped
      end else if (b[7:5] == 3'b110) begin
        pend_nxt = 2'd1;
        part_nxt = {16'd0, b[4:0]};
        bad_nxt  = 1'b0;
      end else if (b[7:4] == 4'b1110) begin
        pend_nxt = 2'd2;
        part_nxt = {17'd0, b[3:0]};
        bad_nxt  = 1'b0;
      end else if (b[7:3] == 5'b11110) begin
        pend_nxt = 2'd3;
        part_nxt = {18'd0, b[2:0]};
        bad_nxt  = 1'b0;
      end else begin
        res_nxt.valid_res  = 1'b1;
        res_nxt.code_point = CP_STAR;
        res_nxt.status     = ST_LEAD;
      end
      if (pend_nxt != 2'd0 && last) begin
        res_nxt.valid_res  = 1'b1;
        res_nxt.code_point = CP_QUEST;
        res_nxt.status     = ST_TRUNC;
      end
    end else begin
      bad_nxt  = bad_r || (b[7:6] != 2'b10);
      part_nxt = {part_r[CP_W-7:0], b[5:0]};
      pend_nxt = pend_r - 2'd1;
      if (pend_r == 2'd1) begin
        res_nxt.valid_res = 1'b1;
        if (bad_nxt) begin
          res_nxt.code_point = CP_QUEST;
          res_nxt.status     = ST_BAD;
        end else begin
          res_nxt.code_point = part_nxt;
        end
        bad_nxt  = 1'b0;
        part_nxt = '0;
      end else if (last) begin
        res_nxt.valid_res  = 1'b1;
        res_nxt.code_point = CP_QUEST;
        res_nxt.status     = ST_TRUNC;
      end
    end
    // string end returns the decoder to idle
    if (last) begin
      pend_nxt = 2'd0;
      part_nxt = '0;
      bad_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pend_r      <= 2'd0;
      part_r      <= '0;
      bad_r       <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
        pend_r      <= pend_nxt;
        part_r      <= part_nxt;
        bad_r       <= bad_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
    if (s1_adv) begin
      out_data_r <= res_nxt;
    end
  end

endmodule

[rtl/utf8d_checker.sv]
// port-level checker for the utf-8 byte stream decoder, with its bind
`timescale 1ns / 1ps

module utf8d_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input utf8d_pkg::out_beat_t out_data
);
  import utf8d_pkg::*;

  // result beat holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  // empty result carries zero code point and ok status
  a_empty_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.valid_res |->
      out_data.code_point == '0 && out_data.status == ST_OK)
    else $error("empty result carries data");

  a_subst_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.valid_res && out_data.status != ST_OK |->
      (out_data.status == ST_LEAD && out_data.code_point == CP_STAR) ||
      (out_data.status != ST_LEAD && out_data.code_point == CP_QUEST))
    else $error("substitute character does not match status");

  a_trunc_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_TRUNC |->
      out_data.string_end && out_data.valid_res)
    else $error("truncation reported away from string end");

endmodule

bind utf8_byte_stream_decoder utf8d_checker u_utf8d_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

[dv/tb_top.sv]
// testbench for the utf-8 byte stream decoder: byte driver, result monitor, scoreboard
`timescale 1ns / 1ps

module tb_top;
  import utf8d_pkg::*;

  // tracks the open utf-8 sequence and queues the result each byte should produce
  class utf8_scoreboard;
    logic [1:0]      seq_left;
    logic [CP_W-1:0] seq_bits;
    logic            seq_bad;
    out_beat_t       char_q[$];
    int              errors;
    int              n_results;
    int              n_chars;
    int              n_status[4];

    function new();
      clear_seq();
      errors = 0;
      n_results = 0;
      n_chars = 0;
      foreach (n_status[i]) n_status[i] = 0;
    endfunction

    function void clear_seq();
      seq_left = '0;
      seq_bits = '0;
      seq_bad  = 1'b0;
    endfunction

    function void note_byte(in_beat_t b);
      out_beat_t  r;
      logic [7:0] v;
      v = b.byte_value;
      r = '0;
      r.string_end = b.last_of_string;
      if (seq_left == 2'd0) begin
        if (v < 8'h20) begin
          r.valid_res = 1'b1;
          r.code_point = CP_SPACE;
        end else if (v < 8'h80) begin
          r.valid_res = 1'b1;
          r.code_point = {13'd0, v};
        end else if (v[7:6] == 2'b10) begin
          // stray continuation, dropped
        end else if (v[7:5] == 3'b110) begin
          seq_left = 2'd1;
          seq_bits = {16'd0, v[4:0]};
          seq_bad = 1'b0;
        end else if (v[7:4] == 4'b1110) begin
          seq_left = 2'd2;
          seq_bits = {17'd0, v[3:0]};
          seq_bad = 1'b0;
        end else if (v[7:3] == 5'b11110) begin
          seq_left = 2'd3;
          seq_bits = {18'd0, v[2:0]};
          seq_bad = 1'b0;
        end else begin
          r.valid_res = 1'b1;
          r.code_point = CP_STAR;
          r.status = ST_LEAD;
        end
        if (seq_left != 2'd0 && b.last_of_string) begin
          r.valid_res = 1'b1;
          r.code_point = CP_QUEST;
          r.status = ST_TRUNC;
        end
      end else begin
        if (v[7:6] != 2'b10) seq_bad = 1'b1;
        seq_bits = {seq_bits[CP_W-7:0], v[5:0]};
        seq_left = seq_left - 2'd1;
        if (seq_left == 2'd0) begin
          r.valid_res = 1'b1;
          if (seq_bad) begin
            r.code_point = CP_QUEST;
            r.status = ST_BAD;
          end else begin
            r.code_point = seq_bits;
            r.status = ST_OK;
          end
          seq_bad = 1'b0;
          seq_bits = '0;
        end else if (b.last_of_string) begin
          // string ended mid-sequence, even after a bad continuation
          r.valid_res = 1'b1;
          r.code_point = CP_QUEST;
          r.status = ST_TRUNC;
        end
      end
      if (b.last_of_string) clear_seq();
      char_q.insert(char_q.size(), r);
    endfunction

    function void compare_field(string name, logic [CP_W-1:0] want, logic [CP_W-1:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      end
    endfunction

    function void check_beat(out_beat_t got);
      out_beat_t want;
      if (char_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none, actual 0x%0h", $time, got);
        return;
      end
      want = char_q.pop_front();
      compare_field("valid_res", CP_W'(want.valid_res), CP_W'(got.valid_res));
      compare_field("code_point", want.code_point, got.code_point);
      compare_field("status", CP_W'(want.status), CP_W'(got.status));
      compare_field("string_end", CP_W'(want.string_end), CP_W'(got.string_end));
      n_results++;
      if (want.valid_res) begin
        n_chars++;
        n_status[want.status]++;
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_beat_t out_data;

  utf8_scoreboard sb;
  int             send_idle_pct;
  int             recv_stall_pct;
  int             bytes_sent;
  logic [7:0]     seq_q[$];

  utf8_byte_stream_decoder i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // call at a rising edge; returns at the edge where the beat is taken
  task automatic send_byte(input logic [7:0] v, input logic last);
    in_beat_t b;
    b.byte_value = v;
    b.last_of_string = last;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (!in_ready);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  function automatic logic [7:0] cont_byte();
    logic [5:0] r;
    r = 6'($urandom);
    return {2'b10, r};
  endfunction

  // one random sequence: mostly well-formed characters, some broken or noise
  function automatic void build_sequence();
    int         kind;
    int         n;
    int         bad_pos;
    logic [7:0] r;
    logic [7:0] c;
    seq_q.delete();
    kind = $urandom_range(0, 99);
    r = 8'($urandom);
    if (kind < 20) begin
      seq_q.insert(seq_q.size(), {1'b0, r[6:0]});
    end else if (kind < 85) begin
      if (kind < 40 || (kind >= 75 && r[0])) n = 2;
      else if (kind < 60 || (kind >= 75 && r[1])) n = 3;
      else n = 4;
      r = 8'($urandom);
      case (n)
        2: seq_q.insert(seq_q.size(), {3'b110, r[4:0]});
        3: seq_q.insert(seq_q.size(), {4'b1110, r[3:0]});
        default: seq_q.insert(seq_q.size(), {5'b11110, r[2:0]});
      endcase
      bad_pos = (kind >= 75) ? $urandom_range(1, n - 1) : 0;
      for (int i = 1; i < n; i++) begin
        if (i == bad_pos) begin
          c = 8'($urandom);
          if (c[7:6] == 2'b10) c[6] = 1'b1;
          seq_q.insert(seq_q.size(), c);
        end else begin
          seq_q.insert(seq_q.size(), cont_byte());
        end
      end
    end else begin
      seq_q.insert(seq_q.size(), r);
    end
  endfunction

  // result side: random back-pressure, check every accepted beat
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) sb.check_beat(out_data);
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  initial begin
    int drain;
    sb = new();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    bytes_sent = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // control, printable and boundary single bytes
    send_byte(8'h00, 1'b0);
    send_byte(8'h1f, 1'b0);
    send_byte(8'h20, 1'b0);
    send_byte(8'h7f, 1'b0);
    // stray continuations
    send_byte(8'h80, 1'b0);
    send_byte(8'hbf, 1'b0);
    // two, three and four byte characters, the last at the top of the range
    send_byte(8'hc2, 1'b0);
    send_byte(8'ha9, 1'b0);
    send_byte(8'he2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'hac, 1'b0);
    send_byte(8'hf7, 1'b0);
    send_byte(8'hbf, 1'b0);
    send_byte(8'hbf, 1'b0);
    send_byte(8'hbf, 1'b0);
    // invalid leads
    send_byte(8'hf8, 1'b0);
    send_byte(8'hff, 1'b0);
    // bad continuation
    send_byte(8'hc3, 1'b0);
    send_byte(8'h41, 1'b0);
    // truncated after a bad continuation, truncated right after the lead
    send_byte(8'he2, 1'b0);
    send_byte(8'h41, 1'b1);
    send_byte(8'hc3, 1'b1);
    // end flag on a dropped byte and on a plain character
    send_byte(8'h80, 1'b1);
    send_byte(8'h41, 1'b1);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      while (bytes_sent < 24 + (ph + 1) * 345) begin
        build_sequence();
        foreach (seq_q[i]) send_byte(seq_q[i], $urandom_range(0, 15) == 0);
      end
    end
    in_valid <= 1'b0;

    drain = 0;
    while (sb.char_q.size() != 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    repeat (10) @(posedge clk);
    if (sb.char_q.size() != 0) begin
      sb.errors += sb.char_q.size();
      $display("%0t: %0d expected result beats never arrived", $time, sb.char_q.size());
    end

    $display("covered %0d bytes and %0d result beats over four back-pressure mixes",
             bytes_sent, sb.n_results);
    $display("%0d characters: %0d decoded, %0d bad continuation, %0d truncated, %0d invalid lead",
             sb.n_chars, sb.n_status[ST_OK], sb.n_status[ST_BAD], sb.n_status[ST_TRUNC],
             sb.n_status[ST_LEAD]);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
